// ===== design/arbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package arbs_pkg;

  // Frame dimension width; width and height are taken modulo 2^DIM_BITS.
  localparam int DIM_BITS = 13;

  // Width of height*16 and width*9 (width*9 stays below width*16).
  localparam int NUM_W = DIM_BITS + 4;

  // Width of the reported ratio fields.
  localparam int RATIO_BITS = 17;

  // Width of the buffer size fields.
  localparam int BUF_BITS = 32;

  // Shift count of the binary GCD and step count of the divider.
  localparam int CNT_W = $clog2(NUM_W + 1);

  // Aligned dimensions may reach 2^DIM_BITS, so they need one more bit.
  localparam int ALIGN_W = DIM_BITS + 1;

  // Width of 2 * aligned width * aligned height.
  localparam int PROD_W = 2 * ALIGN_W + 1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic area_en;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic res_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dim_zero;
    logic gcd_done;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/arbs_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: frame dimensions and recommended buffer size.
interface arbs_in_if;
  logic                                valid;
  logic                                ready;
  logic [arbs_pkg::DIM_BITS-1:0]       frame_width;
  logic [arbs_pkg::DIM_BITS-1:0]       frame_height;
  logic [arbs_pkg::BUF_BITS-1:0]       recommended_size;

  modport source (output valid, frame_width, frame_height, recommended_size, input ready);
  modport sink (input valid, frame_width, frame_height, recommended_size, output ready);
endinterface

// Output channel: reduced ratio, buffer size and error flag.
interface arbs_out_if;
  logic                                valid;
  logic                                ready;
  logic [arbs_pkg::RATIO_BITS-1:0]     ratio_num;
  logic [arbs_pkg::RATIO_BITS-1:0]     ratio_den;
  logic [arbs_pkg::BUF_BITS-1:0]       buffer_bytes;
  logic                                dim_error;

  modport source (output valid, ratio_num, ratio_den, buffer_bytes, dim_error, input ready);
  modport sink (input valid, ratio_num, ratio_den, buffer_bytes, dim_error, output ready);
endinterface

`default_nettype wire

// ===== design/arbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arbs_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  arbs_pkg::dp_status_t status,
  output arbs_pkg::ctrl_cmd_t  cmd
);

  arbs_pkg::state_t state;
  arbs_pkg::state_t state_next;
  logic             out_valid_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= arbs_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      arbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = arbs_pkg::ST_AREA;
        end
      end
      arbs_pkg::ST_AREA: begin
        cmd.area_en = 1'b1;
        if (status.dim_zero) begin
          state_next = arbs_pkg::ST_DONE;
        end else begin
          state_next = arbs_pkg::ST_GCD;
        end
      end
      arbs_pkg::ST_GCD: begin
        if (status.gcd_done) begin
          cmd.div_start = 1'b1;
          state_next    = arbs_pkg::ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      arbs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = arbs_pkg::ST_DONE;
        end
      end
      arbs_pkg::ST_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = arbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = arbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/arbs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module arbs_datapath (
  input  wire                                  clk,
  input  wire [arbs_pkg::DIM_BITS-1:0]         frame_width,
  input  wire [arbs_pkg::DIM_BITS-1:0]         frame_height,
  input  wire [arbs_pkg::BUF_BITS-1:0]         recommended_size,
  input  arbs_pkg::ctrl_cmd_t                  cmd,
  output arbs_pkg::dp_status_t                 status,
  output logic [arbs_pkg::RATIO_BITS-1:0]      ratio_num,
  output logic [arbs_pkg::RATIO_BITS-1:0]      ratio_den,
  output logic [arbs_pkg::BUF_BITS-1:0]        buffer_bytes,
  output logic                                 dim_error
);

  localparam int NW = arbs_pkg::NUM_W;
  localparam int AW = arbs_pkg::ALIGN_W;

  // Stored item.
  logic [arbs_pkg::DIM_BITS-1:0] width_q;
  logic [arbs_pkg::DIM_BITS-1:0] height_q;
  logic [arbs_pkg::BUF_BITS-1:0] rec_q;
  logic [NW-1:0]                 num_q;
  logic [NW-1:0]                 den_q;

  // Binary GCD operands and common power of two.
  logic [NW-1:0]                 gcd_a;
  logic [NW-1:0]                 gcd_b;
  logic [arbs_pkg::CNT_W-1:0]    gcd_k;

  // Shared-divisor restoring dividers for both quotients.
  logic [NW-1:0]                 divisor;
  logic [NW-1:0]                 quo_n;
  logic [NW-1:0]                 quo_d;
  logic [NW-1:0]                 rem_n;
  logic [NW-1:0]                 rem_d;
  logic [arbs_pkg::CNT_W-1:0]    div_cnt;

  // Aligned double frame area.
  logic [arbs_pkg::BUF_BITS-1:0] area_q;

  logic [NW-1:0]                 num_in;
  logic [NW-1:0]                 den_in;
  logic [AW-1:0]                 width_al;
  logic [AW-1:0]                 height_al;
  logic [arbs_pkg::PROD_W-1:0]   area_full;
  logic [63:0]                   area_ext;
  logic [NW:0]                   trial_n;
  logic [NW:0]                   trial_d;
  logic                          fit_n;
  logic                          fit_d;

  // Scaled dimensions: height*16 and width*9 by shift and add.
  assign num_in = {frame_height, 4'b0000};
  assign den_in = {1'b0, frame_width, 3'b000} + NW'(frame_width);

  // Round the width up to 32 and the height up to 16.
  assign width_al  = (AW'(width_q) + AW'(31)) & ~AW'(31);
  assign height_al = (AW'(height_q) + AW'(15)) & ~AW'(15);
  assign area_full = {arbs_pkg::PROD_W'(width_al * height_al)} << 1;
  assign area_ext  = 64'(area_full);

  // One restoring division step for each quotient.
  assign trial_n = {rem_n, quo_n[NW-1]};
  assign trial_d = {rem_d, quo_d[NW-1]};
  assign fit_n   = trial_n >= {1'b0, divisor};
  assign fit_d   = trial_d >= {1'b0, divisor};

  assign status.dim_zero = (width_q == '0) || (height_q == '0);
  assign status.gcd_done = (gcd_a == gcd_b);
  assign status.div_last = (div_cnt == arbs_pkg::CNT_W'(1));

  // Capture the item and seed the GCD.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      width_q  <= frame_width;
      height_q <= frame_height;
      rec_q    <= recommended_size;
      num_q    <= num_in;
      den_q    <= den_in;
    end
  end

  // Binary GCD: one halving or subtract-and-halve step per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gcd_a <= num_in;
      gcd_b <= den_in;
      gcd_k <= '0;
    end else if (cmd.gcd_step) begin
      if (!gcd_a[0] && !gcd_b[0]) begin
        gcd_a <= gcd_a >> 1;
        gcd_b <= gcd_b >> 1;
        gcd_k <= gcd_k + arbs_pkg::CNT_W'(1);
      end else if (!gcd_a[0]) begin
        gcd_a <= gcd_a >> 1;
      end else if (!gcd_b[0]) begin
        gcd_b <= gcd_b >> 1;
      end else if (gcd_a > gcd_b) begin
        gcd_a <= (gcd_a - gcd_b) >> 1;
      end else begin
        gcd_b <= (gcd_b - gcd_a) >> 1;
      end
    end
  end

  // Divide both scaled dimensions by the GCD, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor <= gcd_a << gcd_k;
      quo_n   <= num_q;
      quo_d   <= den_q;
      rem_n   <= '0;
      rem_d   <= '0;
      div_cnt <= arbs_pkg::CNT_W'(NW);
    end else if (cmd.div_step) begin
      rem_n   <= fit_n ? NW'(trial_n - {1'b0, divisor}) : trial_n[NW-1:0];
      rem_d   <= fit_d ? NW'(trial_d - {1'b0, divisor}) : trial_d[NW-1:0];
      quo_n   <= {quo_n[NW-2:0], fit_n};
      quo_d   <= {quo_d[NW-2:0], fit_d};
      div_cnt <= div_cnt - arbs_pkg::CNT_W'(1);
    end
  end

  // Register the saturated area.
  always_ff @(posedge clk) begin
    if (cmd.area_en) begin
      area_q <= (area_ext > 64'hFFFF_FFFF) ? '1 : area_ext[arbs_pkg::BUF_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      dim_error    <= status.dim_zero;
      ratio_num    <= status.dim_zero ? '0 : quo_n[arbs_pkg::RATIO_BITS-1:0];
      ratio_den    <= status.dim_zero ? '0 : quo_d[arbs_pkg::RATIO_BITS-1:0];
      buffer_bytes <= (rec_q > area_q) ? rec_q : area_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/aspect_ratio_and_buffer_size_top.sv =====
// After an item is accepted the controller registers the area (AREA); when width
// or height is zero it goes straight to DONE, else it runs the binary GCD steps
// (GCD) and the 17-step divider (DIV). DONE waits for a free output register.
// One item at a time: the next item is taken once the result enters the output
// register, which holds it until it is taken.
// Reset (synchronous, active high) clears the controller and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module aspect_ratio_and_buffer_size_top (
  input wire         clk,
  input wire         rst,
  arbs_in_if.sink    in_ch,
  arbs_out_if.source out_ch
);

  arbs_pkg::ctrl_cmd_t  cmd;
  arbs_pkg::dp_status_t status;

  // Sequencer.
  arbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // GCD, dividers, area and output register.
  arbs_datapath u_datapath (
    .clk              (clk),
    .frame_width      (in_ch.frame_width),
    .frame_height     (in_ch.frame_height),
    .recommended_size (in_ch.recommended_size),
    .cmd              (cmd),
    .status           (status),
    .ratio_num        (out_ch.ratio_num),
    .ratio_den        (out_ch.ratio_den),
    .buffer_bytes     (out_ch.buffer_bytes),
    .dim_error        (out_ch.dim_error)
  );

endmodule

`default_nettype wire

// ===== bench/arbs_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the result of every accepted item and
// compares each returned result with the oldest prediction.
module arbs_result_checker
  import arbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  arbs_in_if   in_mon,
  arbs_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  // Target shape and alignment steps of the buffer.
  localparam longint unsigned TARGET_H     = 16;
  localparam longint unsigned TARGET_W     = 9;
  localparam longint unsigned WIDTH_ALIGN  = 32;
  localparam longint unsigned HEIGHT_ALIGN = 16;
  localparam longint unsigned AREA_FACTOR  = 2;
  localparam longint unsigned BUF_MAX      = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio_num;
    logic [RATIO_BITS-1:0] ratio_den;
    logic [BUF_BITS-1:0]   buffer_bytes;
    logic                  dim_error;
  } frame_result_t;

  frame_result_t frames_q[$];
  frame_result_t want;
  frame_result_t seen;
  int            mismatches = 0;

  assign fail_count = mismatches;

  initial pending = 0;

  function automatic longint unsigned align_up(input longint unsigned x,
                                               input longint unsigned step);
    return (x + step - 1) / step * step;
  endfunction

  // Reduced 16:9 sample aspect ratio and the buffer size for one frame format.
  function automatic frame_result_t predict_format(input logic [DIM_BITS-1:0] w,
                                                   input logic [DIM_BITS-1:0] h,
                                                   input logic [BUF_BITS-1:0] rec);
    frame_result_t     r;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   x;
    longint unsigned   y;
    longint unsigned   t;
    longint unsigned   quot;
    longint unsigned   area;
    r = '0;
    if (w == 0 || h == 0) begin
      r.dim_error = 1'b1;
    end else begin
      num = longint'(h) * TARGET_H;
      den = longint'(w) * TARGET_W;
      // Euclid's remainder loop; the operand order does not matter here.
      x = num;
      y = den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      quot = num / x;
      r.ratio_num = quot[RATIO_BITS-1:0];
      quot = den / x;
      r.ratio_den = quot[RATIO_BITS-1:0];
    end
    area = AREA_FACTOR * align_up(longint'(w), WIDTH_ALIGN)
         * align_up(longint'(h), HEIGHT_ALIGN);
    if (area > BUF_MAX) area = BUF_MAX;
    if (longint'(rec) > area) r.buffer_bytes = rec;
    else r.buffer_bytes = area[BUF_BITS-1:0];
    return r;
  endfunction

  task automatic report_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Results are retired before new items are queued, since a result taken in
  // the same cycle as an item always belongs to an earlier item.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_mon.valid && out_mon.ready) begin
        seen.ratio_num    = out_mon.ratio_num;
        seen.ratio_den    = out_mon.ratio_den;
        seen.buffer_bytes = out_mon.buffer_bytes;
        seen.dim_error    = out_mon.dim_error;
        if (frames_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual num %0d den %0d buf %0d err %0d",
                   $time, seen.ratio_num, seen.ratio_den, seen.buffer_bytes, seen.dim_error);
          mismatches++;
        end else begin
          want = frames_q.pop_front();
          report_field("ratio_num", want.ratio_num, seen.ratio_num);
          report_field("ratio_den", want.ratio_den, seen.ratio_den);
          report_field("buffer_bytes", want.buffer_bytes, seen.buffer_bytes);
          report_field("dim_error", want.dim_error, seen.dim_error);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        frames_q.push_back(predict_format(in_mon.frame_width, in_mon.frame_height,
                                          in_mon.recommended_size));
      end
      pending <= frames_q.size();
    end
  end

endmodule

// ===== bench/tb_aspect_ratio_and_buffer_size_top.sv =====
`timescale 1ns / 1ps

module tb_aspect_ratio_and_buffer_size_top;
  import arbs_pkg::*;

  localparam int RANDOM_FRAMES = 1700;
  localparam int MAX_GAP       = 17;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 80;
  localparam int FULL_DIM      = (1 << DIM_BITS) - 1;
  localparam int MAX_MULT      = FULL_DIM / 16;

  logic clk;
  logic rst;
  logic in_calm;
  logic out_calm;
  int   fail_count;
  int   pending;
  int   stall_left;
  int   stall_draw;
  int   quiet_cycles;

  arbs_in_if  in_ch();
  arbs_out_if out_ch();

  aspect_ratio_and_buffer_size_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  arbs_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: after each taken result, hold ready low for a random stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_draw = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      stall_left   <= stall_draw;
      out_ch.ready <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offers one frame format after a random gap and waits until it is taken.
  // Valid stays high after the handshake so back-to-back items need no toggle.
  task automatic send_format(input int w, input int h,
                             input logic [BUF_BITS-1:0] rec);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.frame_width      <= DIM_BITS'(w);
    in_ch.frame_height     <= DIM_BITS'(h);
    in_ch.recommended_size <= rec;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Stops offering items until every outstanding result has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [DIM_BITS-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel <= 5) return DIM_BITS'($urandom_range(1, 64));
    if (sel <= 7) return DIM_BITS'(FULL_DIM - $urandom_range(0, 15));
    return DIM_BITS'($urandom_range(0, FULL_DIM));
  endfunction

  // Sizes near the largest aligned area so that both sides of the maximum occur.
  function automatic logic [BUF_BITS-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return BUF_BITS'($urandom_range(0, 1 << 27));
      4:       return BUF_BITS'($urandom_range(0, 1 << 20));
      default: return BUF_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    int                  k;
    rst                    = 1'b1;
    in_calm                = 1'b0;
    out_calm               = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.frame_width      = '0;
    in_ch.frame_height     = '0;
    in_ch.recommended_size = '0;
    out_ch.ready           = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed formats: zero dimensions, extremes, exact 16:9 and area edges.
    send_format(0, 0, 0);
    send_format(0, 1080, 0);
    send_format(1920, 0, 5);
    send_format(0, 0, '1);
    send_format(1920, 1080, 0);
    send_format(FULL_DIM, FULL_DIM, 0);
    send_format(FULL_DIM, FULL_DIM, '1);
    send_format(FULL_DIM, 1, 0);
    send_format(1, FULL_DIM, 0);
    send_format(1, 1, 0);
    send_format(1, 1, 1024);
    send_format(1, 1, 1025);
    send_format(1, 1, '1);
    send_format(640, 480, 614399);
    send_format(640, 480, 614400);
    send_format(640, 480, 614401);
    send_format(720, 576, 0);
    send_format(720, 480, 32'h8000_0000);
    send_format(4096, 4096, 0);
    send_format(16, 9, 0);
    send_format(33, 17, 1);
    wait_drained();

    // Random formats in phases that switch idling on and off on each side.
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      if (i % 100 == 0) begin
        in_calm  <= ($urandom_range(0, 3) == 0);
        out_calm <= ($urandom_range(0, 3) == 0);
      end
      if (i % 400 == 399) wait_drained();
      if ($urandom_range(0, 9) == 0) begin
        // Whole multiples of 16:9 reduce to one over one.
        k = $urandom_range(1, MAX_MULT);
        w = DIM_BITS'(16 * k);
        h = DIM_BITS'(9 * k);
      end else begin
        w = pick_dim();
        h = pick_dim();
      end
      send_format(int'(w), int'(h), pick_size());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
